### hw/rtl/bspl_pkg.sv
// Shared types, codes and fixed-point helpers for the B-spline basis evaluator.
// Used by bspl_div, bspl_core and the top level bspline_nonzero_basis_eval.
package bspl_pkg;

	localparam int MAX_ORDER = 7;
	localparam int MAX_KNOTS = 64;
	localparam int KA_W      = $clog2(MAX_KNOTS);
	localparam int KC_W      = $clog2(MAX_KNOTS + 1);
	localparam int NUM_W     = 35;
	localparam logic signed [31:0] Q_ONE = 32'sd65536;

	// item kinds carried in tuser
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_VALUE = 2'd1;
	localparam logic [1:0] FUNC_DERIV = 2'd2;

	// configuration register indexes
	localparam logic REG_ORDER = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef struct packed {
		logic                    start;
		logic signed [NUM_W-1:0] num;
		logic signed [31:0]      den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quot;
	} div_rsp_t;

	typedef struct packed {
		logic               valid;
		logic [2:0]         idx;
		logic signed [31:0] value;
		logic               last;
	} emit_t;

	// clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat49(input logic signed [48:0] v);
		logic signed [31:0] r;
		begin
			if (v > 49'sd2147483647) begin
				r = 32'sh7fffffff;
			end else if (v < -49'sd2147483648) begin
				r = 32'sh80000000;
			end else begin
				r = v[31:0];
			end
			return r;
		end
	endfunction

	// scale a Q32.32 product back to Q16.16, rounding toward zero
	function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
		logic signed [63:0] adj;
		begin
			adj = p + (p[63] ? 64'sd65535 : 64'sd0);
			return sat49({adj[63], adj[63:16]});
		end
	endfunction

endpackage

### hw/rtl/bspline_nonzero_basis_eval.sv
// Top level of the B-spline nonzero basis evaluator: config registers and output register.
// Depends on bspl_pkg and instantiates bspl_core.
//
//  channel  | direction | carries
//  s_axis   | in        | tuser: func; tdata: knot_index, knot_value, position, span_index
//  m_axis   | out       | tdata: basis_index, basis_value; tlast: last
//  apb      | in/out    | reg 0 spline_order at 0x0, reg 1 knot_count at 0x4
//
// A load item is written straight into the knot memory. An evaluate item of degree n
// spends, per triangle entry, one serial division and then three multiply and write-back
// states, over n*(n+1)/2 entries, one row fewer in derivative mode; the derivative pass
// adds n+1 divisions, each edge search step visits S_EDGE and S_ECHK, and n+1 items are
// output at the end. Most of the run time is spent in the shared serial divider.
// Reset clears control only. A stalled m_tready holds the output register and, while it emits, the sequencer.
module bspline_nonzero_basis_eval import bspl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // knot_index, knot_value, position, span_index, zero pad
	input  logic [1:0]  s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // basis_index, basis_value, zero pad
	output logic        m_tlast,   // last
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [2:0]         order_q;
	logic [6:0]         count_q;
	logic [KC_W-1:0]    kc_eff;
	emit_t              emit;
	logic               emit_ready;
	logic               out_valid_q;
	logic [2:0]         out_idx_q;
	logic signed [31:0] out_val_q;
	logic               out_last_q;

	assign pready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 3'd3;
			count_q <= 7'd64;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_ORDER: order_q <= pwdata[2:0];
				REG_COUNT: count_q <= pwdata[6:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_ORDER: prdata = {29'd0, order_q};
			REG_COUNT: prdata = {25'd0, count_q};
			default:   prdata = 32'd0;
		endcase
	end

	// clamp the knot count to the store depth
	assign kc_eff = (count_q > 7'(MAX_KNOTS)) ? KC_W'(MAX_KNOTS) : KC_W'(count_q);

	bspl_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.func         (s_tuser),
		.knot_index   (s_tdata[5:0]),
		.knot_value   (s_tdata[37:6]),
		.position     (s_tdata[69:38]),
		.span_index   (s_tdata[75:70]),
		.spline_order (order_q),
		.knot_count   (kc_eff),
		.emit         (emit),
		.emit_ready   (emit_ready)
	);

	// output register: take a new item when empty or being drained
	assign emit_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_ready) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_ready && emit.valid) begin
			out_idx_q  <= emit.idx;
			out_val_q  <= emit.value;
			out_last_q <= emit.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_val_q, out_idx_q};
	assign m_tlast  = out_last_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output item changed while stalled");

	a_busy_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input taken in the middle of a run");

	a_order_kept: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready && !(psel && penable && pwrite) |=> $stable(order_q))
		else $error("degree changed during a run");

endmodule

### hw/rtl/bspl_div.sv
// Serial signed Q16.16 divider: one quotient bit per cycle, saturating.
// Depends on bspl_pkg for the request and response types.
module bspl_div import bspl_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int DVD_W = NUM_W + 16;
	localparam int CNT_W = $clog2(DVD_W);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DVD_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [31:0]       rem_q;
	logic [31:0]       dvs_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVD_W-1:0]  quo_q;
	logic              neg_q;
	logic signed [31:0] res_q;

	logic [32:0]       trial;
	logic              ge;
	logic [32:0]       rem_n;
	logic [DVD_W-1:0]  quo_n;
	logic [NUM_W-1:0]  num_mag;
	logic [31:0]       den_mag;
	logic signed [31:0] fin;

	assign num_mag = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
	assign den_mag = req.den[31] ? 32'(-req.den) : 32'(req.den);

	// one restoring step
	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign rem_n = ge ? trial - {1'b0, dvs_q} : trial;
	assign quo_n = {quo_q[DVD_W-2:0], ge};

	// saturate the magnitude and apply the sign
	always_comb begin
		if (neg_q) begin
			if (quo_n > DVD_W'(64'd2147483648)) begin
				fin = 32'sh80000000;
			end else begin
				fin = -$signed(quo_n[31:0]);
			end
		end else begin
			if (quo_n > DVD_W'(64'd2147483647)) begin
				fin = 32'sh7fffffff;
			end else begin
				fin = $signed(quo_n[31:0]);
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_CNT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				cnt_q <= '0;
				if (req.den == 32'sd0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= rem_n[31:0];
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			quo_q <= quo_n;
			if (cnt_q == LAST_CNT) begin
				res_q <= fin;
			end
		end else if (req.start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= {num_mag, 16'd0};
			dvs_q <= den_mag;
			neg_q <= req.num[NUM_W-1] ^ req.den[31];
			res_q <= 32'sd0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = res_q;

endmodule

### hw/rtl/bspl_core.sv
// Knot memory and sequencer for the basis triangle, derivative pass and output order.
// Depends on bspl_pkg and instantiates bspl_div.
module bspl_core import bspl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         func,
	input  logic [5:0]         knot_index,
	input  logic signed [31:0] knot_value,
	input  logic signed [31:0] position,
	input  logic [5:0]         span_index,
	input  logic [2:0]         spline_order,
	input  logic [KC_W-1:0]    knot_count,
	output emit_t              emit,
	input  logic               emit_ready
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_EDGE = 5'd1;
	localparam logic [4:0] S_ECHK = 5'd2;
	localparam logic [4:0] S_JS   = 5'd3;
	localparam logic [4:0] S_K1   = 5'd4;
	localparam logic [4:0] S_K2   = 5'd5;
	localparam logic [4:0] S_DEN  = 5'd6;
	localparam logic [4:0] S_DIV  = 5'd7;
	localparam logic [4:0] S_MA   = 5'd8;
	localparam logic [4:0] S_MB   = 5'd9;
	localparam logic [4:0] S_MC   = 5'd10;
	localparam logic [4:0] S_DS   = 5'd11;
	localparam logic [4:0] S_DK1  = 5'd12;
	localparam logic [4:0] S_DK2  = 5'd13;
	localparam logic [4:0] S_DDN  = 5'd14;
	localparam logic [4:0] S_DDP  = 5'd15;
	localparam logic [4:0] S_EMIT = 5'd16;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_DOWN = 2'd1;
	localparam logic [1:0] DIR_UP   = 2'd2;

	logic [4:0]          state_q;
	logic [1:0]          dir_q;
	logic                deriv_q;
	logic                zero_q;
	logic [2:0]          n_q;
	logic [2:0]          steps_q;
	logic [KC_W-1:0]     kc_q;
	logic signed [7:0]   left_q;
	logic [2:0]          j_q;
	logic [2:0]          i_q;
	logic [2:0]          m_q;
	logic [2:0]          e_q;

	logic signed [31:0]  x_q;
	logic signed [31:0]  term_q;
	logic signed [31:0]  saved_q;
	logic signed [31:0]  prev_q;
	logic signed [31:0]  negres_q;
	logic signed [31:0]  ka_val_q;
	logic signed [31:0]  dd_q;
	logic signed [63:0]  prod_q;
	logic signed [31:0]  bw_q [MAX_ORDER+1];
	logic signed [31:0]  rd_q [MAX_ORDER];
	logic signed [31:0]  ld_q [MAX_ORDER];

	logic signed [31:0]  knot_mem [MAX_KNOTS];
	logic signed [31:0]  mrd_q;
	logic                mok_q;

	div_req_t            dreq;
	div_rsp_t            drsp;

	logic signed [8:0]   ka;
	logic                ka_ok;
	logic signed [31:0]  kv;
	logic signed [8:0]   left9;
	logic signed [8:0]   n9;
	logic signed [8:0]   kc9;
	logic [2:0]          jmi;
	logic [2:0]          mm1;
	logic signed [31:0]  den_sum;
	logic signed [31:0]  dval;
	logic signed [NUM_W-1:0] nt;
	logic signed [63:0]  prod_d;
	logic signed [31:0]  mq;
	logic signed [8:0]   sh1;
	logic signed [8:0]   sh2;
	logic signed [8:0]   e9;
	logic signed [8:0]   src;
	logic signed [31:0]  ev;
	logic signed [8:0]   span9;
	logic signed [8:0]   nin9;
	logic                emit_fire;

	bspl_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign left9 = 9'(left_q);
	assign n9    = $signed({6'd0, n_q});
	assign kc9   = $signed(9'(kc_q));
	assign jmi   = j_q - i_q;
	assign mm1   = m_q - 3'd1;
	assign in_ready  = state_q == S_IDLE;
	assign emit_fire = emit.valid && emit_ready;

	// knot address for the read issued in this state
	always_comb begin
		case (state_q)
			S_EDGE:  ka = (dir_q == DIR_UP) ? left9 + 9'sd1 : left9;
			S_JS:    ka = left9 + $signed({6'd0, j_q}) + 9'sd1;
			S_K1:    ka = left9 - $signed({6'd0, j_q});
			S_DS:    ka = left9 + $signed({6'd0, m_q});
			S_DK1:   ka = left9 + $signed({6'd0, m_q}) - n9;
			default: ka = 9'sd0;
		endcase
	end
	assign ka_ok = (ka >= 9'sd0) && (ka < kc9);
	assign kv    = mok_q ? mrd_q : 32'sd0;

	// knot memory: one write port for load items, one registered read port
	always_ff @(posedge clk) begin
		if (in_valid && in_ready && func == FUNC_LOAD) begin
			knot_mem[knot_index] <= knot_value;
		end
		mrd_q <= knot_mem[ka[KA_W-1:0]];
		mok_q <= ka_ok;
	end

	// arithmetic feeding the divider and the multiplier
	assign den_sum = sat49(49'(33'(rd_q[i_q]) + 33'(ld_q[jmi])));
	assign dval    = sat49(49'(33'(ka_val_q) - 33'(kv)));
	assign nt      = NUM_W'(bw_q[mm1]) * NUM_W'({1'b0, n_q});
	assign prod_d  = 64'(rd_q[i_q]) * 64'(term_q);
	assign mq      = mulq(prod_q);

	always_comb begin
		dreq.start = 1'b0;
		dreq.num   = NUM_W'(bw_q[i_q]);
		dreq.den   = den_sum;
		case (state_q)
			S_DEN: begin
				dreq.start = 1'b1;
			end
			S_DK2: begin
				dreq.start = 1'b1;
				dreq.num   = (m_q == 3'd1) ? -nt : nt;
				dreq.den   = dval;
			end
			S_DDN: begin
				dreq.start = drsp.done;
				dreq.num   = nt;
				dreq.den   = dd_q;
			end
			default: begin
				dreq.start = 1'b0;
			end
		endcase
	end

	// output order: shift valid values and zero-fill partly supported spans
	assign sh1 = n9 - left9;
	assign sh2 = left9 + n9 + 9'sd2 - kc9;
	assign e9  = $signed({6'd0, e_q});
	always_comb begin
		src = e9;
		ev  = 32'sd0;
		if (sh1 > 9'sd0) begin
			src = e9 + sh1;
			ev  = (e9 <= left9) ? bw_q[src[2:0]] : 32'sd0;
		end else if (sh2 > 9'sd0) begin
			src = e9 - sh2;
			ev  = (e9 >= sh2) ? bw_q[src[2:0]] : 32'sd0;
		end else begin
			ev  = bw_q[e_q];
		end
		if (zero_q) begin
			ev = 32'sd0;
		end
	end

	assign emit.valid = state_q == S_EMIT;
	assign emit.idx   = e_q;
	assign emit.value = ev;
	assign emit.last  = zero_q || (e_q == n_q);

	assign span9 = $signed({3'd0, span_index});
	assign nin9  = $signed({6'd0, spline_order});

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dir_q   <= DIR_NONE;
			deriv_q <= 1'b0;
			zero_q  <= 1'b0;
			n_q     <= '0;
			steps_q <= '0;
			kc_q    <= '0;
			left_q  <= '0;
			j_q     <= '0;
			i_q     <= '0;
			m_q     <= '0;
			e_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid && (func == FUNC_VALUE || func == FUNC_DERIV)) begin
						deriv_q <= func == FUNC_DERIV;
						n_q     <= spline_order;
						kc_q    <= knot_count;
						left_q  <= $signed({2'd0, span_index});
						j_q     <= '0;
						e_q     <= '0;
						m_q     <= 3'd1;
						steps_q <= (func == FUNC_VALUE) ? spline_order : spline_order - 3'd1;
						zero_q  <= func == FUNC_DERIV && spline_order == 3'd0;
						if (span9 == nin9) begin
							dir_q <= DIR_DOWN;
						end else if (span9 == $signed(9'(knot_count)) - nin9 - 9'sd2) begin
							dir_q <= DIR_UP;
						end else begin
							dir_q <= DIR_NONE;
						end
						if (func == FUNC_DERIV && spline_order == 3'd0) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_EDGE;
						end
					end
				end
				// widen the span at the table edges
				S_EDGE: begin
					if (dir_q == DIR_DOWN && left_q >= 8'sd0) begin
						state_q <= S_ECHK;
					end else if (dir_q == DIR_UP && left9 < kc9 - 9'sd1) begin
						state_q <= S_ECHK;
					end else begin
						state_q <= S_JS;
					end
				end
				S_ECHK: begin
					if (dir_q == DIR_DOWN && x_q < kv) begin
						left_q  <= left_q - 8'sd1;
						state_q <= S_EDGE;
					end else if (dir_q == DIR_UP && x_q > kv) begin
						left_q  <= left_q + 8'sd1;
						state_q <= S_EDGE;
					end else begin
						state_q <= S_JS;
					end
				end
				// one row of the triangle
				S_JS: begin
					if (j_q == steps_q) begin
						state_q <= deriv_q ? S_DS : S_EMIT;
					end else begin
						state_q <= S_K1;
					end
				end
				S_K1: state_q <= S_K2;
				S_K2: begin
					i_q     <= '0;
					state_q <= S_DEN;
				end
				S_DEN: state_q <= S_DIV;
				S_DIV: begin
					if (drsp.done) begin
						state_q <= S_MA;
					end
				end
				S_MA: state_q <= S_MB;
				S_MB: state_q <= S_MC;
				S_MC: begin
					if (i_q == j_q) begin
						j_q     <= j_q + 3'd1;
						state_q <= S_JS;
					end else begin
						i_q     <= i_q + 3'd1;
						state_q <= S_DEN;
					end
				end
				// derivative differences
				S_DS:  state_q <= S_DK1;
				S_DK1: state_q <= S_DK2;
				S_DK2: state_q <= (m_q == 3'd1) ? S_DDN : S_DDP;
				S_DDN: begin
					if (drsp.done) begin
						state_q <= S_DDP;
					end
				end
				S_DDP: begin
					if (drsp.done) begin
						if (m_q == n_q) begin
							state_q <= S_EMIT;
						end else begin
							m_q     <= m_q + 3'd1;
							state_q <= S_DS;
						end
					end
				end
				// hand out one item per basis function
				S_EMIT: begin
					if (emit_fire) begin
						if (emit.last) begin
							state_q <= S_IDLE;
						end else begin
							e_q <= e_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working values
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q      <= position;
				bw_q[0]  <= Q_ONE;
			end
			S_K1: rd_q[j_q] <= sat49(49'(33'(kv) - 33'(x_q)));
			S_K2: begin
				ld_q[j_q] <= sat49(49'(33'(x_q) - 33'(kv)));
				saved_q   <= 32'sd0;
			end
			S_DIV: begin
				if (drsp.done) begin
					term_q <= drsp.quot;
				end
			end
			S_MA: prod_q <= prod_d;
			S_MB: begin
				bw_q[i_q] <= sat49(49'(33'(saved_q) + 33'(mq)));
				prod_q    <= 64'(ld_q[jmi]) * 64'(term_q);
			end
			S_MC: begin
				saved_q <= mq;
				if (i_q == j_q) begin
					bw_q[j_q + 3'd1] <= mq;
				end
			end
			S_DK1: ka_val_q <= kv;
			S_DK2: dd_q     <= dval;
			S_DDN: begin
				if (drsp.done) begin
					negres_q <= drsp.quot;
				end
			end
			S_DDP: begin
				if (drsp.done) begin
					prev_q <= drsp.quot;
					if (m_q == 3'd1) begin
						bw_q[0] <= negres_q;
					end else begin
						bw_q[mm1] <= sat49(49'(33'(prev_q) - 33'(drsp.quot)));
					end
					if (m_q == n_q) begin
						bw_q[n_q] <= drsp.quot;
					end
				end
			end
			default: begin
			end
		endcase
	end

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		emit.valid && emit.last && !zero_q |-> e_q == n_q)
		else $error("last flag away from the final basis function");

	a_eval_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == FUNC_VALUE || func == FUNC_DERIV)
		|=> state_q != S_IDLE)
		else $error("evaluate item dropped");

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> state_q == S_DIV || state_q == S_DDN || state_q == S_DDP)
		else $error("division finished with nobody waiting");

	a_no_start_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !dreq.start)
		else $error("divider started while idle");

endmodule
